// ----- hw/rtl/cbpa_pkg.sv -----
// shared widths, register codes and rounding helper for the bezier point and aim block
`default_nettype none

package cbpa_pkg;

  // coordinate, curve parameter and aim formats
  localparam int unsigned CoordW = 16;
  localparam int unsigned ParamF = 16;
  localparam int unsigned AimF   = 14;

  // curve parameter and weight widths
  localparam int unsigned TW = ParamF + 2;
  localparam int unsigned TB = ParamF + 1;
  localparam int unsigned WW = ParamF + 3;
  localparam int unsigned PW = WW + 1 + CoordW;
  localparam int unsigned AW = PW + 2;
  localparam int unsigned DW = CoordW + 1;

  // squared distances and aim quotient
  localparam int unsigned SQW = 2 * CoordW;
  localparam int unsigned LW  = SQW + 2;
  localparam int unsigned QW  = 2 * AimF + 3;
  localparam int unsigned DivSteps  = QW;
  localparam int unsigned SqrtSteps = AimF + 2;
  localparam int unsigned AimLat    = 1 + DivSteps + SqrtSteps;
  localparam int unsigned AimW      = AimF + 2;

  localparam logic [TB-1:0] ONE  = {1'b1, {ParamF{1'b0}}};
  localparam logic [2*TB-1:0] HALF = (2*TB)'(1) << (ParamF - 1);

  // configuration port
  localparam int unsigned NumRegs = 5;
  localparam int unsigned RegW    = 3 * CoordW;
  localparam int unsigned DataW   = 64;
  localparam int unsigned AddrW   = 6;

  localparam logic [2:0] REG_CP0 = 3'd0;
  localparam logic [2:0] REG_CP1 = 3'd1;
  localparam logic [2:0] REG_CP2 = 3'd2;
  localparam logic [2:0] REG_CP3 = 3'd3;
  localparam logic [2:0] REG_TGT = 3'd4;

  // per-item data riding alongside the aim units
  typedef struct packed {
    logic [2:0][CoordW-1:0] pos;
    logic [2:0]             neg;
    logic                   deg;
  } pipe_t;

  // product of two weights in q1.16, rounded half up
  function automatic logic [TB-1:0] rnd_mul(input logic [TB-1:0] a, input logic [TB-1:0] b);
    logic [2*TB-1:0] p;
    p = (2*TB)'(a) * (2*TB)'(b) + HALF;
    return p[ParamF +: TB];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cbpa_aim_unit.sv -----
// pipelined exact divide and square root giving one rounded aim magnitude
`default_nettype none

module cbpa_aim_unit (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [cbpa_pkg::SQW-1:0]      sq_i,
  input  logic [cbpa_pkg::LW-1:0]       len2_i,
  output logic [cbpa_pkg::AimF:0]       mag_o
);

  localparam int unsigned LW  = cbpa_pkg::LW;
  localparam int unsigned QW  = cbpa_pkg::QW;
  localparam int unsigned NDV = cbpa_pkg::DivSteps;
  localparam int unsigned NSQ = cbpa_pkg::SqrtSteps;
  localparam int unsigned AF  = cbpa_pkg::AimF;

  // divide stages: quotient of sq * 2^(2a+2) by len2
  logic [LW-1:0] rem_q  [NDV+1];
  logic [LW-1:0] len_q  [NDV+1];
  logic [QW-1:0] quot_q [NDV+1];

  logic [LW:0]   dv_sh  [NDV];
  logic [LW:0]   dv_sub [NDV];
  logic          dv_ge  [NDV];
  logic [LW-1:0] dv_rem_d [NDV];

  always_comb begin
    for (int k = 0; k < NDV; k++) begin
      dv_sh[k]    = (k == 0) ? {1'b0, rem_q[k]} : {rem_q[k], 1'b0};
      dv_ge[k]    = dv_sh[k] >= {1'b0, len_q[k]};
      dv_sub[k]   = dv_sh[k] - {1'b0, len_q[k]};
      dv_rem_d[k] = dv_ge[k] ? dv_sub[k][LW-1:0] : dv_sh[k][LW-1:0];
    end
  end

  // square root stages, one result bit each
  logic [QW:0] num_q [NSQ];
  logic [QW:0] res_q [NSQ];

  logic [QW:0] sn [NSQ];
  logic [QW:0] sr [NSQ];
  logic [QW:0] sb [NSQ];
  logic [QW:0] ss [NSQ];
  logic        sg [NSQ];
  logic [QW:0] num_d [NSQ];
  logic [QW:0] res_d [NSQ];

  always_comb begin
    sn[0] = {1'b0, quot_q[NDV]};
    sr[0] = '0;
    for (int j = 1; j < NSQ; j++) begin
      sn[j] = num_q[j-1];
      sr[j] = res_q[j-1];
    end
    for (int j = 0; j < NSQ; j++) begin
      sb[j]    = (QW+1)'(1) << (2 * (NSQ - 1 - j));
      ss[j]    = sr[j] + sb[j];
      sg[j]    = sn[j] >= ss[j];
      num_d[j] = sg[j] ? sn[j] - ss[j] : sn[j];
      res_d[j] = sg[j] ? (sr[j] >> 1) + sb[j] : (sr[j] >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= LW'(sq_i);
      len_q[0]  <= len2_i;
      quot_q[0] <= '0;
      for (int k = 0; k < NDV; k++) begin
        rem_q[k+1]  <= dv_rem_d[k];
        len_q[k+1]  <= len_q[k];
        quot_q[k+1] <= {quot_q[k][QW-2:0], dv_ge[k]};
      end
      for (int j = 0; j < NSQ; j++) begin
        num_q[j] <= num_d[j];
        res_q[j] <= res_d[j];
      end
    end
  end

  // aim magnitude is (isqrt + 1) / 2
  logic [AF+2:0] rq;
  assign rq    = {1'b0, res_q[NSQ-1][AF+1:0]} + (AF+3)'(1);
  assign mag_o = rq[AF+1:1];

endmodule

`default_nettype wire

// ----- hw/rtl/cubic_bezier_point_and_aim_top.sv -----
// top level of the cubic bezier point and aim block
// 6 curve stages, 48 aim stages and 1 output register lie between item acceptance and result
// valid
// throughput: one item per cycle; the whole pipeline advances unless the result is stalled
// the aim path is an input register, a 31-stage restoring divider and a 16-stage square root
// per axis; reset clears all valid bits and the five configuration registers to zero
// config writes take effect at once; write only while no item is in flight
`default_nettype none

module cubic_bezier_point_and_aim_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // apb-style configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cbpa_pkg::AddrW-1:0]        paddr,
  input  logic [cbpa_pkg::DataW-1:0]        pwdata,
  output logic [cbpa_pkg::DataW-1:0]        prdata,
  output logic                              pready,
  // input item channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [cbpa_pkg::TW-1:0]    curve_param_i,
  // result item channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [cbpa_pkg::CoordW-1:0] pos_x_o,
  output logic signed [cbpa_pkg::CoordW-1:0] pos_y_o,
  output logic signed [cbpa_pkg::CoordW-1:0] pos_z_o,
  output logic signed [cbpa_pkg::AimW-1:0]  aim_x_o,
  output logic signed [cbpa_pkg::AimW-1:0]  aim_y_o,
  output logic signed [cbpa_pkg::AimW-1:0]  aim_z_o,
  output logic                              aim_degenerate_o
);

  localparam int unsigned CW  = cbpa_pkg::CoordW;
  localparam int unsigned TB  = cbpa_pkg::TB;
  localparam int unsigned WW  = cbpa_pkg::WW;
  localparam int unsigned PW  = cbpa_pkg::PW;
  localparam int unsigned AW  = cbpa_pkg::AW;
  localparam int unsigned DW  = cbpa_pkg::DW;
  localparam int unsigned SQW = cbpa_pkg::SQW;
  localparam int unsigned LW  = cbpa_pkg::LW;
  localparam int unsigned LAT = cbpa_pkg::AimLat;
  localparam int unsigned AF  = cbpa_pkg::AimF;
  localparam int unsigned AMW = cbpa_pkg::AimW;
  localparam int unsigned PF  = cbpa_pkg::ParamF;

  localparam logic signed [AW-1:0] PHALF = AW'(1) << (PF - 1);
  localparam logic signed [AW-PF-1:0] PMAX = (AW-PF)'((1 << (CW - 1)) - 1);
  localparam logic signed [AW-PF-1:0] PMIN = -(AW-PF)'(1 << (CW - 1));

  // ---------------------------------------------------------------- config registers
  logic [cbpa_pkg::RegW-1:0] cfg_q [cbpa_pkg::NumRegs];
  logic                      cfg_wr;
  logic [2:0]                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[cbpa_pkg::AddrW-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cbpa_pkg::NumRegs; i++) cfg_q[i] <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        cbpa_pkg::REG_CP0: cfg_q[0] <= pwdata[cbpa_pkg::RegW-1:0];
        cbpa_pkg::REG_CP1: cfg_q[1] <= pwdata[cbpa_pkg::RegW-1:0];
        cbpa_pkg::REG_CP2: cfg_q[2] <= pwdata[cbpa_pkg::RegW-1:0];
        cbpa_pkg::REG_CP3: cfg_q[3] <= pwdata[cbpa_pkg::RegW-1:0];
        cbpa_pkg::REG_TGT: cfg_q[4] <= pwdata[cbpa_pkg::RegW-1:0];
        default: ;  // unmapped addresses drop the write
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      cbpa_pkg::REG_CP0: prdata = cbpa_pkg::DataW'(cfg_q[0]);
      cbpa_pkg::REG_CP1: prdata = cbpa_pkg::DataW'(cfg_q[1]);
      cbpa_pkg::REG_CP2: prdata = cbpa_pkg::DataW'(cfg_q[2]);
      cbpa_pkg::REG_CP3: prdata = cbpa_pkg::DataW'(cfg_q[3]);
      cbpa_pkg::REG_TGT: prdata = cbpa_pkg::DataW'(cfg_q[4]);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow control
  // one enable for every stage: everything moves unless the result is held
  logic       adv;
  logic [5:0] vs_q;       // valid bits of curve stages 1..6
  logic       out_vld_q;

  assign adv        = ~(out_vld_q & out_stall_i);
  assign in_stall_o = ~adv;

  // ---------------------------------------------------------------- stage 1: clamp t
  logic [TB-1:0] t1_q, u1_q, t_d;

  always_comb begin
    if (curve_param_i[cbpa_pkg::TW-1]) begin
      t_d = '0;
    end else if (curve_param_i[TB-1:0] > cbpa_pkg::ONE) begin
      t_d = cbpa_pkg::ONE;
    end else begin
      t_d = curve_param_i[TB-1:0];
    end
  end

  // ---------------------------------------------------------------- stage 2: squares
  logic [TB-1:0] t2_q, u2_q, tt2_q, uu2_q;

  // ---------------------------------------------------------------- stage 3: bernstein weights
  logic [WW-1:0] w_q [4];
  logic [TB-1:0] m_u3, m_ut, m_tu, m_t3;

  assign m_u3 = cbpa_pkg::rnd_mul(uu2_q, u2_q);
  assign m_ut = cbpa_pkg::rnd_mul(uu2_q, t2_q);
  assign m_tu = cbpa_pkg::rnd_mul(tt2_q, u2_q);
  assign m_t3 = cbpa_pkg::rnd_mul(tt2_q, t2_q);

  // ---------------------------------------------------------------- stage 4: weighted control points
  logic signed [PW-1:0] prod_q [4][3];
  logic signed [PW-1:0] prod_d [4][3];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[k][c] = $signed({1'b0, w_q[k]}) * $signed(cfg_q[k][c*CW +: CW]);
      end
    end
  end

  // ---------------------------------------------------------------- stage 5: sum, round, saturate
  logic signed [CW-1:0] pos5_q [3];
  logic signed [DW-1:0] d5_q   [3];
  logic signed [AW-1:0] acc    [3];
  logic signed [AW-PF-1:0] pr  [3];
  logic signed [CW-1:0] ps     [3];
  logic signed [CW-1:0] tgt    [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = AW'(prod_q[0][c]) + AW'(prod_q[1][c]) + AW'(prod_q[2][c])
             + AW'(prod_q[3][c]) + PHALF;
      pr[c]  = acc[c][AW-1:PF];
      if (pr[c] > PMAX) begin
        ps[c] = PMAX[CW-1:0];
      end else if (pr[c] < PMIN) begin
        ps[c] = PMIN[CW-1:0];
      end else begin
        ps[c] = pr[c][CW-1:0];
      end
      tgt[c] = $signed(cfg_q[4][c*CW +: CW]);
    end
  end

  // ---------------------------------------------------------------- stage 6: squared offsets
  logic [SQW-1:0]       sq6_q  [3];
  logic [2:0]           neg6_q;
  logic signed [CW-1:0] pos6_q [3];
  logic [DW-1:0]        mag    [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mag[c] = d5_q[c][DW-1] ? DW'(-d5_q[c]) : DW'(d5_q[c]);
    end
  end

  // ---------------------------------------------------------------- squared length feeds the aim units
  logic [LW-1:0] len2;
  logic          deg;

  assign len2 = LW'(sq6_q[0]) + LW'(sq6_q[1]) + LW'(sq6_q[2]);
  assign deg  = (len2 == '0);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_q  <= t_d;
      u1_q  <= cbpa_pkg::ONE - t_d;
      t2_q  <= t1_q;
      u2_q  <= u1_q;
      tt2_q <= cbpa_pkg::rnd_mul(t1_q, t1_q);
      uu2_q <= cbpa_pkg::rnd_mul(u1_q, u1_q);
      w_q[0] <= WW'(m_u3);
      w_q[1] <= (WW'(m_ut) << 1) + WW'(m_ut);
      w_q[2] <= (WW'(m_tu) << 1) + WW'(m_tu);
      w_q[3] <= WW'(m_t3);
      prod_q <= prod_d;
      for (int c = 0; c < 3; c++) begin
        pos5_q[c] <= ps[c];
        d5_q[c]   <= DW'(tgt[c]) - DW'(ps[c]);
        sq6_q[c]  <= SQW'(mag[c][CW-1:0]) * SQW'(mag[c][CW-1:0]);
        neg6_q[c] <= d5_q[c][DW-1];
        pos6_q[c] <= pos5_q[c];
      end
    end
  end

  // ---------------------------------------------------------------- aim units, one per axis
  logic [AF:0] aim_mag [3];

  for (genvar g = 0; g < 3; g++) begin : g_aim
    cbpa_aim_unit u_aim (
      .clk_i  (clk_i),
      .en_i   (adv),
      .sq_i   (sq6_q[g]),
      .len2_i (len2),
      .mag_o  (aim_mag[g])
    );
  end

  // side line carrying position, signs and the degenerate flag past the aim units
  cbpa_pkg::pipe_t dl_q [LAT];
  logic [LAT-1:0]  dv_q;
  cbpa_pkg::pipe_t dl_in;

  always_comb begin
    for (int c = 0; c < 3; c++) dl_in.pos[c] = pos6_q[c];
    dl_in.neg = neg6_q;
    dl_in.deg = deg;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dl_q[0] <= dl_in;
      for (int s = 1; s < LAT; s++) dl_q[s] <= dl_q[s-1];
    end
  end

  // ---------------------------------------------------------------- valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q      <= '0;
      dv_q      <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vs_q      <= {vs_q[4:0], in_valid_i};
      dv_q      <= {dv_q[LAT-2:0], vs_q[5]};
      out_vld_q <= dv_q[LAT-1];
    end
  end

  // ---------------------------------------------------------------- output register
  logic signed [AMW-1:0] aim_d [3];
  cbpa_pkg::pipe_t       tail;

  assign tail = dl_q[LAT-1];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (tail.deg) begin
        aim_d[c] = '0;
      end else if (tail.neg[c]) begin
        aim_d[c] = -$signed({1'b0, aim_mag[c]});
      end else begin
        aim_d[c] = $signed({1'b0, aim_mag[c]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_x_o          <= tail.pos[0];
      pos_y_o          <= tail.pos[1];
      pos_z_o          <= tail.pos[2];
      aim_x_o          <= aim_d[0];
      aim_y_o          <= aim_d[1];
      aim_z_o          <= aim_d[2];
      aim_degenerate_o <= tail.deg;
    end
  end

  assign out_valid_o = out_vld_q;

  // ---------------------------------------------------------------- assertions
  // degenerate result carries a zero direction
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && aim_degenerate_o |-> aim_x_o == '0 && aim_y_o == '0 && aim_z_o == '0)
    else $error("degenerate result with nonzero aim");

  // a real direction always has a nonzero component
  a_dir_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !aim_degenerate_o |-> aim_x_o != '0 || aim_y_o != '0 || aim_z_o != '0)
    else $error("nondegenerate result with zero aim");

  // aim components stay within plus or minus one
  a_aim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> aim_x_o <= 16'sd16384 && aim_x_o >= -16'sd16384
                 && aim_y_o <= 16'sd16384 && aim_y_o >= -16'sd16384
                 && aim_z_o <= 16'sd16384 && aim_z_o >= -16'sd16384)
    else $error("aim component out of range");

endmodule

`default_nettype wire

// ----- test/cubic_bezier_point_and_aim_top_test.sv -----
// self-checking testbench for the cubic bezier point and aim block
`timescale 1ns / 100ps

module cubic_bezier_point_and_aim_top_test;

  localparam int unsigned  CoordW  = cbpa_pkg::CoordW;
  localparam int unsigned  ParamF  = cbpa_pkg::ParamF;
  localparam int unsigned  AimF    = cbpa_pkg::AimF;
  localparam int unsigned  AimW    = cbpa_pkg::AimW;
  localparam int unsigned  TW      = cbpa_pkg::TW;
  localparam int unsigned  RegW    = cbpa_pkg::RegW;
  localparam int unsigned  NumRegs = cbpa_pkg::NumRegs;
  localparam int unsigned  DataW   = cbpa_pkg::DataW;
  localparam int unsigned  AddrW   = cbpa_pkg::AddrW;

  localparam int unsigned  Drain    = 80;           // a little over the pipeline latency
  localparam logic [2:0]   RegBogus = 3'd5;         // index past the register file
  localparam int unsigned  ItemsPerPhase = 100;
  localparam int unsigned  NumPhases     = 13;
  localparam int unsigned  HoldCycles    = 300;     // long receiver hold-off
  localparam int unsigned  HoldPhase     = 5;

  // one curve point with its aim vector
  typedef struct {
    logic signed [CoordW-1:0] px, py, pz;
    logic signed [AimW-1:0]   ax, ay, az;
    logic                     deg;
  } point_aim_t;

  // expected curve points and the register copy they are computed from
  class point_scoreboard;
    logic [RegW-1:0] regs [NumRegs];
    point_aim_t      pending [$];
    int              errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      errors = 0;
    endfunction

    function void reg_write(logic [2:0] idx, logic [DataW-1:0] val);
      if (idx < NumRegs) regs[idx] = val[RegW-1:0];
    endfunction

    function longint coord(int r, int c);
      logic signed [CoordW-1:0] v;
      v = regs[r][CoordW*c +: CoordW];
      return longint'(v);
    endfunction

    function longint rnd(longint x);
      return (x + (64'sd1 <<< (ParamF - 1))) >>> ParamF;
    endfunction

    // largest q with (2q-1)^2 * len2 <= d^2 * 2^(2A+2), q <= 2^A
    function longint aim_of(longint d, logic [127:0] len2);
      logic [127:0] mag, lhs, rhs, odd;
      longint q, cand;
      mag = d < 0 ? -d : d;
      q = 0;
      for (int b = AimF; b >= 0; b--) begin
        cand = q | (64'sd1 <<< b);
        odd = 2 * cand - 1;
        lhs = odd * odd * len2;
        rhs = (mag * mag) << (2 * AimF + 2);
        if (cand <= (64'sd1 <<< AimF) && lhs <= rhs) q = cand;
      end
      return d < 0 ? -q : q;
    endfunction

    function void note(logic [TW-1:0] raw);
      longint t, u, u2, t2, acc, p, dsq, d[3];
      longint w[4];
      logic [127:0] len2;
      longint pos[3];
      point_aim_t e;
      if (raw[TW-1]) t = 0;
      else t = raw > (1 << ParamF) ? (1 << ParamF) : longint'(raw);
      u = (1 << ParamF) - t;
      u2 = rnd(u * u);
      t2 = rnd(t * t);
      w[0] = rnd(u2 * u);
      w[1] = 3 * rnd(u2 * t);
      w[2] = 3 * rnd(t2 * u);
      w[3] = rnd(t2 * t);
      len2 = '0;
      for (int c = 0; c < 3; c++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += w[k] * coord(k, c);
        p = (acc + (64'sd1 <<< (ParamF - 1))) >>> ParamF;
        if (p > (1 <<< (CoordW - 1)) - 1) p = (1 <<< (CoordW - 1)) - 1;
        if (p < -(1 <<< (CoordW - 1))) p = -(1 <<< (CoordW - 1));
        pos[c] = p;
        d[c] = coord(cbpa_pkg::REG_TGT, c) - p;
        dsq = d[c] * d[c];
        len2 = len2 + 128'(dsq);
      end
      e.px = CoordW'(pos[0]);
      e.py = CoordW'(pos[1]);
      e.pz = CoordW'(pos[2]);
      e.deg = (len2 == 0);
      e.ax = e.deg ? '0 : AimW'(aim_of(d[0], len2));
      e.ay = e.deg ? '0 : AimW'(aim_of(d[1], len2));
      e.az = e.deg ? '0 : AimW'(aim_of(d[2], len2));
      pending.push_back(e);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check(point_aim_t got);
      point_aim_t e;
      if (pending.size() == 0) begin
        report("unexpected item", 1, 0);
        return;
      end
      e = pending.pop_front();
      if (got.px !== e.px) report("pos_x", got.px, e.px);
      if (got.py !== e.py) report("pos_y", got.py, e.py);
      if (got.pz !== e.pz) report("pos_z", got.pz, e.pz);
      if (got.ax !== e.ax) report("aim_x", got.ax, e.ax);
      if (got.ay !== e.ay) report("aim_y", got.ay, e.ay);
      if (got.az !== e.az) report("aim_z", got.az, e.az);
      if (got.deg !== e.deg) report("aim_degenerate", got.deg, e.deg);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [TW-1:0] curve_param_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [CoordW-1:0] pos_x_o, pos_y_o, pos_z_o;
  logic signed [AimW-1:0] aim_x_o, aim_y_o, aim_z_o;
  logic aim_degenerate_o;

  point_scoreboard points = new();
  int unsigned burst_left = 0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;

  cubic_bezier_point_and_aim_top DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // result monitor: sample at the rising edge
  always @(posedge clk_i) begin
    point_aim_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.px = pos_x_o;
      got.py = pos_y_o;
      got.pz = pos_z_o;
      got.ax = aim_x_o;
      got.ay = aim_y_o;
      got.az = aim_z_o;
      got.deg = aim_degenerate_o;
      points.check(got);
    end
  end

  // receiver stall pattern: shifting stall density, plus one long hold-off
  // while items keep coming, so the pipeline fills and pushes back on the input
  initial begin
    int unsigned cyc, density, hold_left;
    cyc = 0;
    density = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 400 == 0) density = $urandom_range(0, 3) * 25;  // 0, 25, 50 or 75 percent
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = ($urandom_range(0, 99) < density);
      end
    end
  end

  // one register write: setup cycle then access cycle
  task cfg_write(logic [2:0] idx, logic [DataW-1:0] val);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 3'b000};
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    points.reg_write(idx, val);
  endtask

  // hand one item to the block, holding it until it is taken
  task send_param(logic [TW-1:0] t);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    curve_param_i = t;
    do @(posedge clk_i); while (in_stall_o);
    points.note(t);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  // let every result come back, then the pipeline settle
  task drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (points.pending.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  function logic [DataW-1:0] pack_point(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                                        logic [CoordW-1:0] z);
    logic [15:0] junk;
    junk = 16'($urandom);  // bits above the register are ignored by the block
    return {junk, z, y, x};
  endfunction

  function logic [CoordW-1:0] rand_coord(int unsigned mode);
    case (mode)
      0: begin
        return CoordW'($urandom);
      end
      1: begin
        return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end
      default: begin
        return CoordW'($urandom_range(0, 2000) - 1000);
      end
    endcase
  endfunction

  function logic [TW-1:0] rand_param();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return '0;
    if (pick < 10) return TW'(1 << ParamF);
    if (pick < 15) return TW'($urandom_range(1 << ParamF, (1 << (TW - 1)) - 1));
    if (pick < 22) return TW'($urandom);                  // any 18-bit pattern
    return TW'($urandom_range(0, 1 << ParamF));
  endfunction

  initial begin
    logic [TW-1:0] directed [$];
    logic [DataW-1:0] val;
    int unsigned mode;
    directed = '{18'h20000, 18'h3ffff, 18'h00000, 18'h00001, 18'h08000,
                 18'h0ffff, 18'h10000, 18'h10001, 18'h1ffff, 18'h0c000};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // registers at reset: every point and the target sit at the origin, so aim is degenerate
    no_gaps = 1'b1;
    foreach (directed[i]) send_param(directed[i]);
    drain();

    // all points at the top corner, target at the bottom: weights summing past one saturate
    for (int r = 0; r < 4; r++) cfg_write(3'(r), pack_point(16'h7fff, 16'h7fff, 16'h7fff));
    cfg_write(cbpa_pkg::REG_TGT, pack_point(16'h8000, 16'h8000, 16'h8000));
    cfg_write(RegBogus, 64'hffff_ffff_ffff_ffff);  // out of range, must be dropped
    foreach (directed[i]) send_param(directed[i]);
    drain();

    // all points at the bottom corner, aim straight along one axis
    for (int r = 0; r < 4; r++) cfg_write(3'(r), pack_point(16'h8000, 16'h8000, 16'h8000));
    cfg_write(cbpa_pkg::REG_TGT, pack_point(16'h7fff, 16'h8000, 16'h8000));
    foreach (directed[i]) send_param(directed[i]);
    drain();

    // random phases with fresh register settings each time
    no_gaps = 1'b0;
    for (int ph = 0; ph < NumPhases; ph++) begin
      mode = ph % 3;
      no_gaps = (ph % 4 == 3);
      for (int r = 0; r < 4; r++)
        cfg_write(3'(r), pack_point(rand_coord(mode), rand_coord(mode), rand_coord(mode)));
      case ($urandom_range(0, 3))
        0: begin
          // target on the first point: t at or below zero lands on it
          val = {16'h0, points.regs[cbpa_pkg::REG_CP0]};
        end
        1: begin
          // target on the last point
          val = {16'h0, points.regs[cbpa_pkg::REG_CP3]};
        end
        default: begin
          val = pack_point(rand_coord(mode), rand_coord(mode), rand_coord(mode));
        end
      endcase
      cfg_write(cbpa_pkg::REG_TGT, val);
      if (ph == HoldPhase) hold_req = 1'b1;
      for (int n = 0; n < ItemsPerPhase; n++) send_param(rand_param());
      drain();
    end

    if (points.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
